>>> src/mchd_pkg.sv
// Shared types and constants for the Manchester edge-timing decoder.
// No dependencies; every other file imports this package.
package mchd_pkg;

    localparam int GAP_W  = 16;
    localparam int CFG_W  = 16;
    localparam int BYTE_W = 8;
    localparam int BIB_W  = 4;
    localparam int POS_W  = 2;
    localparam int CIDX_W = 2;

    localparam logic [BIB_W-1:0] BYTE_BITS = 4'd8;

    // Register indexes on the configuration port
    localparam logic [CIDX_W-1:0] CFG_SHORT_MIN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SHORT_MAX = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_LONG_MIN  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_LONG_MAX  = 2'd3;

    localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd400;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd650;
    localparam logic [CFG_W-1:0] LONG_MIN_RST  = 16'd900;
    localparam logic [CFG_W-1:0] LONG_MAX_RST  = 16'd1150;

    typedef enum logic [2:0] {
        ST_WAIT  = 3'd0,
        ST_START = 3'd1,
        ST_MSG   = 3'd2,
        ST_MSG2  = 3'd3,
        ST_STOP  = 3'd4,
        ST_STOP2 = 3'd5,
        ST_DONE  = 3'd6
    } rx_state_t;

    typedef enum logic [1:0] {
        GAP_NONE  = 2'd0,
        GAP_SHORT = 2'd1,
        GAP_LONG  = 2'd2
    } gap_kind_t;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_START  = 3'd1,
        PH_DATA   = 3'd2,
        PH_STOP   = 3'd3,
        PH_DONE   = 3'd4,
        PH_REJECT = 3'd5
    } rx_phase_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_PHASE = 2'd2
    } err_kind_t;

    typedef struct packed {
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] short_max;
        logic [CFG_W-1:0] long_min;
        logic [CFG_W-1:0] long_max;
    } win_cfg_t;

    // Listed MSB first so rx_phase lands in the lowest bits
    typedef struct packed {
        logic              ones_parity;
        logic              frame_done;
        logic [POS_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic              byte_valid;
        err_kind_t         error_kind;
        rx_phase_t         rx_phase;
    } rx_result_t;

    localparam int RES_W   = $bits(rx_result_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

>>> src/mchd_classify.sv
// Interval classifier: sorts one edge gap into short, long or neither.
// Depends on mchd_pkg.
module mchd_classify
    import mchd_pkg::*;
(
    input  logic [GAP_W-1:0] gap,
    input  win_cfg_t         win,
    output gap_kind_t        kind
);

    logic in_short;
    logic in_long;

    assign in_short = (gap >= win.short_min) && (gap <= win.short_max);
    assign in_long  = (gap >= win.long_min) && (gap <= win.long_max);

    // Short window wins where the two overlap
    always_comb begin
        if (in_short) begin
            kind = GAP_SHORT;
        end else if (in_long) begin
            kind = GAP_LONG;
        end else begin
            kind = GAP_NONE;
        end
    end

endmodule

>>> src/mchd_rx.sv
// Receive machine: start bit, data bits, stop bit, byte assembly and parity.
// Depends on mchd_pkg; takes the gap class from mchd_classify.
module mchd_rx
    import mchd_pkg::*;
#(
    parameter int FRAME_LENGTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  gap_kind_t  kind,
    output rx_result_t result
);

    localparam int CNT_W = $clog2(FRAME_LENGTH + 1);

    rx_state_t          state_reg, state_next;
    logic               last_bit_reg, last_bit_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [BIB_W-1:0]   bib_reg, bib_next;
    logic [CNT_W-1:0]   bif_reg, bif_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               parity_reg, parity_next;

    logic               store;
    err_kind_t          err;
    logic [BYTE_W-1:0]  shift_or;
    logic [BIB_W-1:0]   bib_inc;
    logic [CNT_W-1:0]   frame_inc;
    rx_phase_t          phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_WAIT;
            last_bit_reg <= 1'b0;
            shift_reg    <= '0;
            bib_reg      <= '0;
            bif_reg      <= '0;
            pos_reg      <= '0;
            parity_reg   <= 1'b0;
        end else if (step) begin
            state_reg    <= state_next;
            last_bit_reg <= last_bit_next;
            shift_reg    <= shift_next;
            bib_reg      <= bib_next;
            bif_reg      <= bif_next;
            pos_reg      <= pos_next;
            parity_reg   <= parity_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        last_bit_next = last_bit_reg;
        shift_next    = shift_reg;
        bib_next      = bib_reg;
        bif_next      = bif_reg;
        pos_next      = pos_reg;
        parity_next   = parity_reg;
        store         = 1'b0;
        err           = ERR_NONE;
        result        = '0;

        // Phase transitions; outside the waiting state, any gap outside both windows is rejected
        case (state_reg)
            ST_START: begin
                if (kind == GAP_NONE) begin
                    err = ERR_RANGE;
                end else if (kind == GAP_SHORT) begin
                    last_bit_next = 1'b1;
                    pos_next      = '0;
                    bif_next      = '0;
                    bib_next      = '0;
                    shift_next    = '0;
                    parity_next   = 1'b0;
                    state_next    = ST_MSG;
                end else begin
                    err = ERR_PHASE;
                end
            end
            ST_MSG: begin
                if (kind == GAP_NONE) begin
                    err = ERR_RANGE;
                end else if (kind == GAP_LONG) begin
                    last_bit_next = ~last_bit_reg;
                    store         = 1'b1;
                end else begin
                    state_next = ST_MSG2;
                end
            end
            ST_MSG2: begin
                if (kind == GAP_NONE) begin
                    err = ERR_RANGE;
                end else if (kind == GAP_SHORT) begin
                    store = 1'b1;
                end else begin
                    err = ERR_PHASE;
                end
            end
            ST_STOP: begin
                if (kind == GAP_NONE) begin
                    err = ERR_RANGE;
                end else if (kind == GAP_LONG) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_STOP2;
                end
            end
            ST_STOP2: begin
                if (kind == GAP_NONE) begin
                    err = ERR_RANGE;
                end else if (kind == GAP_SHORT) begin
                    state_next = ST_DONE;
                end else begin
                    err = ERR_PHASE;
                end
            end
            ST_DONE: begin
                if (kind == GAP_NONE) begin
                    err = ERR_RANGE;
                end
            end
            default: begin
                // First edge is not classed; unused codes behave as waiting
                state_next = ST_START;
            end
        endcase

        // Shift in the bit, update parity and close out bytes and frames
        shift_or  = shift_reg | {{(BYTE_W-1){1'b0}}, last_bit_next};
        bib_inc   = bib_reg + 1'b1;
        frame_inc = bif_reg + 1'b1;
        if (store) begin
            parity_next = parity_reg ^ last_bit_next;
            bib_next    = bib_inc;
            bif_next    = frame_inc;
            if (frame_inc == CNT_W'(FRAME_LENGTH)) begin
                result.byte_valid = 1'b1;
                result.byte_value = shift_or;
                result.byte_index = pos_reg;
                shift_next        = shift_or;
                state_next        = ST_STOP;
            end else if (bib_inc == BYTE_BITS) begin
                result.byte_valid = 1'b1;
                result.byte_value = shift_or;
                result.byte_index = pos_reg;
                pos_next          = pos_reg + 1'b1;
                bib_next          = '0;
                shift_next        = '0;
                state_next        = ST_MSG;
            end else begin
                shift_next = {shift_or[BYTE_W-2:0], 1'b0};
                state_next = ST_MSG;
            end
        end

        if (err != ERR_NONE) begin
            state_next = ST_WAIT;
        end

        case (state_next)
            ST_START:          phase = PH_START;
            ST_MSG, ST_MSG2:   phase = PH_DATA;
            ST_STOP, ST_STOP2: phase = PH_STOP;
            ST_DONE:           phase = PH_DONE;
            default:           phase = PH_WAIT;
        endcase

        result.rx_phase    = (err != ERR_NONE) ? PH_REJECT : phase;
        result.error_kind  = err;
        result.frame_done  = (state_next == ST_DONE);
        result.ones_parity = parity_next;
    end

endmodule

>>> src/manchester_edge_timing_decoder.sv
// Top level of the Manchester edge-timing decoder: ports, window registers,
// input and result registers. Depends on mchd_pkg, mchd_classify and mchd_rx.
//
//  channel  | dir | accept              | content
//  ---------+-----+---------------------+-----------------------------------
//  s_       | in  | s_tvalid & s_tready | one edge gap, 16 bit timer ticks
//  m_       | out | m_tvalid & m_tready | one decode result per edge
//  cfg_     | in  | cfg_wr_en           | window bounds, indexes 0 to 3
//
// One edge in, one result out. An edge is decoded while it sits in the input
// register and appears on m_ in the cycle after it is decoded. With m_tready
// held high a new edge is taken every cycle; the rate is set by the receive
// state update, done once per decoded edge. A stalled result holds in the
// result register while one more edge waits in the input register; s_tready
// drops only when both are full and m_tready is low. aresetn is synchronous
// and restores the default windows and the waiting phase.
module manchester_edge_timing_decoder
    import mchd_pkg::*;
#(
    parameter int FRAME_LENGTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [GAP_W-1:0]    s_tdata,   // [15:0] edge_interval

    output logic                m_tvalid,
    input  logic                m_tready,
    // [2:0] rx_phase, [4:3] error_kind, [5] byte_valid, [13:6] byte_value,
    // [15:14] byte_index, [16] frame_done, [17] ones_parity, [23:18] zero
    output logic [TDATA_W-1:0]  m_tdata,

    input  logic                cfg_wr_en,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    win_cfg_t         win_reg;
    logic             in_valid_reg;
    logic [GAP_W-1:0] in_gap_reg;
    logic             out_valid_reg;
    rx_result_t       out_res_reg;

    logic             advance;
    gap_kind_t        kind;
    rx_result_t       res_next;

    // Window registers: one write per cycle, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.short_min <= SHORT_MIN_RST;
            win_reg.short_max <= SHORT_MAX_RST;
            win_reg.long_min  <= LONG_MIN_RST;
            win_reg.long_max  <= LONG_MAX_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SHORT_MIN: win_reg.short_min <= cfg_wdata;
                CFG_SHORT_MAX: win_reg.short_max <= cfg_wdata;
                CFG_LONG_MIN:  win_reg.long_min  <= cfg_wdata;
                CFG_LONG_MAX:  win_reg.long_max  <= cfg_wdata;
                default:       win_reg.short_min <= win_reg.short_min;
            endcase
        end
    end

    // Decode the held edge when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_gap_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    mchd_classify u_classify (
        .gap  (in_gap_reg),
        .win  (win_reg),
        .kind (kind)
    );

    mchd_rx #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_rx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .kind    (kind),
        .result  (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-RES_W){1'b0}}, out_res_reg};

`ifndef SYNTHESIS
    // A byte never completes on a rejected edge
    a_byte_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.byte_valid) |-> (out_res_reg.error_kind == ERR_NONE))
        else $error("byte completed on a rejected edge");

    // Error reported exactly when the phase shows a rejection
    a_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_res_reg.error_kind != ERR_NONE)
                      == (out_res_reg.rx_phase == PH_REJECT)))
        else $error("error kind and rejected phase disagree");

    // Frame done flag tracks the done phase
    a_done_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_res_reg.frame_done == (out_res_reg.rx_phase == PH_DONE)))
        else $error("frame_done does not match done phase");

    // A result leaves only after an edge was decoded into it
    a_out_from_in: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result appeared without a held edge");
`endif

endmodule
